// ----- rtl/core/svf_pkg.sv -----
// shared types, widths and codes for the state variable filter
package svf_pkg;

  // field and datapath widths
  localparam int SampleW = 16;
  localparam int CoefW   = 18;
  localparam int StateW  = 21;
  localparam int FracW   = 16;
  localparam int OpW     = 25;
  localparam int AccW    = 44;
  localparam int RndW    = AccW - FracW;
  localparam int CfgIdxW = 3;
  localparam int ModeW   = 3;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_A1 = 3'd0,
    CFG_COEF_A2 = 3'd1,
    CFG_COEF_A3 = 3'd2,
    CFG_DAMPING = 3'd3,
    CFG_MODE    = 3'd4
  } cfg_reg_t;

  // response select codes
  typedef enum logic [ModeW-1:0] {
    MODE_LOWPASS  = 3'd0,
    MODE_BANDPASS = 3'd1,
    MODE_HIGHPASS = 3'd2,
    MODE_NOTCH    = 3'd3,
    MODE_PEAK     = 3'd4
  } mode_t;

  // sequencer states, one per serial product plus idle and write-back
  typedef enum logic [2:0] {
    S_IDLE,
    S_A1_IC1,
    S_A2_V3,
    S_A2_IC1,
    S_A3_V3,
    S_K_V1,
    S_FINISH
  } svf_state_t;

  // control from sequencer to the serial multiplier
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  // divide by 2^16, round half toward plus infinity
  function automatic logic signed [RndW-1:0] round_q16(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] sum;
    sum = x + {{(AccW-FracW){1'b0}}, 1'b1, {(FracW-1){1'b0}}};
    return sum[AccW-1:FracW];
  endfunction

endpackage

// ----- rtl/core/svf_mac.sv -----
// bit-serial multiply-accumulate, one coefficient bit per cycle
module svf_mac #(
  parameter int OpW   = svf_pkg::OpW,
  parameter int CoefW = svf_pkg::CoefW,
  parameter int AccW  = svf_pkg::AccW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  svf_pkg::mac_ctl_t      ctl,
  input  logic signed [OpW-1:0]  operand,
  input  logic [CoefW-1:0]       coef,
  output logic                   busy,
  output logic                   done,
  output logic signed [AccW-1:0] acc
);

  localparam int CntW = $clog2(CoefW);

  logic [CoefW-1:0]       coef_sr;
  logic signed [AccW-1:0] mcand;
  logic [CntW-1:0]        count;

  // control: run for one pass over the coefficient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CntW'(CoefW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift coefficient right, multiplicand left, add on a set bit
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      coef_sr <= coef;
      mcand   <= {{(AccW-OpW){operand[OpW-1]}}, operand};
      if (ctl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      coef_sr <= coef_sr >> 1;
      mcand   <= mcand <<< 1;
      if (coef_sr[0]) begin
        acc <= acc + mcand;
      end
    end
  end

endmodule

// ----- rtl/core/state_variable_filter.sv -----
// trapezoidal state variable filter, top level with sequencer and output register
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+--------------------------
//  in      | in_valid in_ready sample_in      | into      | one Q1.15 sample
//  out     | out_valid out_ready sample_out   | out of    | one response and clip flag
//          | clipped                          |           |
//  cfg     | cfg_valid cfg_ready cfg_index    | into      | one register write
//          | cfg_data                         |           |
//
// A sample runs five products on one bit-serial multiplier, each over the 18
// coefficient bits plus launch and hand-off, then write-back.
// The next sample is taken as soon as write-back is done, even if the result
// still waits in the output register; write-back holds while that register is full.
// Reset clears the integrators and loads the register defaults; in and cfg are
// not ready while reset is high, cfg is ready at all other times.
module state_variable_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [svf_pkg::SampleW-1:0] sample_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [svf_pkg::SampleW-1:0] sample_out,
  output logic                               clipped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [svf_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [svf_pkg::CoefW-1:0]          cfg_data
);

  localparam int SW = svf_pkg::StateW;

  // configuration registers
  logic [svf_pkg::CoefW-1:0] coef_a1;
  logic [svf_pkg::CoefW-1:0] coef_a2;
  logic [svf_pkg::CoefW-1:0] coef_a3;
  logic [svf_pkg::CoefW-1:0] damping;
  logic [svf_pkg::ModeW-1:0] filter_mode;

  // filter state and per-sample values
  logic signed [SW-1:0]                first_integrator;
  logic signed [SW-1:0]                second_integrator;
  logic signed [svf_pkg::SampleW-1:0]  v0;
  logic signed [24:0]                  v1;
  logic signed [25:0]                  v2;
  logic signed [21:0]                  v3;

  // sequencer
  svf_pkg::svf_state_t state, state_next;
  logic                launched, launched_next;
  svf_pkg::mac_ctl_t   mac_ctl;
  logic signed [svf_pkg::OpW-1:0]   mac_op;
  logic [svf_pkg::CoefW-1:0]        mac_coef;
  logic                             mac_busy;
  logic                             mac_done;
  logic signed [svf_pkg::AccW-1:0]  mac_acc;
  logic signed [svf_pkg::RndW-1:0]  acc_rnd;
  logic                             wb_fire;

  // write-back arithmetic
  logic signed [26:0] kv1;
  logic signed [26:0] s1;
  logic signed [27:0] s2;
  logic signed [28:0] y;
  logic signed [SW-1:0] s1_sat;
  logic signed [SW-1:0] s2_sat;
  logic signed [svf_pkg::SampleW-1:0] y_sat;
  logic clip_s1, clip_s2, clip_y;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (state == svf_pkg::S_IDLE);
  assign wb_fire   = (state == svf_pkg::S_FINISH) && (!out_valid || out_ready);

  // configuration writes, excess index codes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a1     <= svf_pkg::CoefW'(65536);
      coef_a2     <= '0;
      coef_a3     <= '0;
      damping     <= svf_pkg::CoefW'(65536);
      filter_mode <= svf_pkg::MODE_LOWPASS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        svf_pkg::CFG_COEF_A1: coef_a1     <= cfg_data;
        svf_pkg::CFG_COEF_A2: coef_a2     <= cfg_data;
        svf_pkg::CFG_COEF_A3: coef_a3     <= cfg_data;
        svf_pkg::CFG_DAMPING: damping     <= cfg_data;
        svf_pkg::CFG_MODE:    filter_mode <= cfg_data[svf_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  // v3 = v0 - ic2
  assign v3 = {{6{v0[15]}}, v0} - {second_integrator[SW-1], second_integrator};

  // multiplier operand and coefficient per product
  always_comb begin
    case (state)
      svf_pkg::S_A1_IC1: begin
        mac_op   = {{4{first_integrator[SW-1]}}, first_integrator};
        mac_coef = coef_a1;
      end
      svf_pkg::S_A2_V3: begin
        mac_op   = {{3{v3[21]}}, v3};
        mac_coef = coef_a2;
      end
      svf_pkg::S_A2_IC1: begin
        mac_op   = {{4{first_integrator[SW-1]}}, first_integrator};
        mac_coef = coef_a2;
      end
      svf_pkg::S_A3_V3: begin
        mac_op   = {{3{v3[21]}}, v3};
        mac_coef = coef_a3;
      end
      svf_pkg::S_K_V1: begin
        mac_op   = v1;
        mac_coef = damping;
      end
      default: begin
        mac_op   = '0;
        mac_coef = '0;
      end
    endcase
  end

  svf_mac #(
    .OpW   (svf_pkg::OpW),
    .CoefW (svf_pkg::CoefW),
    .AccW  (svf_pkg::AccW)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .operand (mac_op),
    .coef    (mac_coef),
    .busy    (mac_busy),
    .done    (mac_done),
    .acc     (mac_acc)
  );

  assign acc_rnd = svf_pkg::round_q16(mac_acc);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= svf_pkg::S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  // next state and multiplier launch
  always_comb begin
    state_next    = state;
    launched_next = launched;
    mac_ctl.start = 1'b0;
    mac_ctl.clear = 1'b0;
    case (state)
      svf_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = svf_pkg::S_A1_IC1;
        end
      end
      svf_pkg::S_A1_IC1, svf_pkg::S_A2_V3, svf_pkg::S_A2_IC1,
      svf_pkg::S_A3_V3, svf_pkg::S_K_V1: begin
        if (!launched) begin
          mac_ctl.start = 1'b1;
          mac_ctl.clear = (state != svf_pkg::S_A2_V3) && (state != svf_pkg::S_A3_V3);
          launched_next = 1'b1;
        end else if (mac_done) begin
          launched_next = 1'b0;
          case (state)
            svf_pkg::S_A1_IC1: state_next = svf_pkg::S_A2_V3;
            svf_pkg::S_A2_V3:  state_next = svf_pkg::S_A2_IC1;
            svf_pkg::S_A2_IC1: state_next = svf_pkg::S_A3_V3;
            svf_pkg::S_A3_V3:  state_next = svf_pkg::S_K_V1;
            default:           state_next = svf_pkg::S_FINISH;
          endcase
        end
      end
      svf_pkg::S_FINISH: begin
        if (wb_fire) begin
          state_next = svf_pkg::S_IDLE;
        end
      end
      default: state_next = svf_pkg::S_IDLE;
    endcase
  end

  // sample capture and intermediate results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      v0 <= sample_in;
    end
    if (mac_done && launched && state == svf_pkg::S_A2_V3) begin
      v1 <= acc_rnd[24:0];
    end
    if (mac_done && launched && state == svf_pkg::S_A3_V3) begin
      v2 <= {{5{second_integrator[SW-1]}}, second_integrator} + acc_rnd[25:0];
    end
  end

  // new states: 2*v - ic, saturated to 21 bits
  assign s1 = {v1[24], v1, 1'b0} - {{6{first_integrator[SW-1]}}, first_integrator};
  assign s2 = {v2[25], v2, 1'b0} - {{7{second_integrator[SW-1]}}, second_integrator};

  always_comb begin
    clip_s1 = 1'b1;
    if (s1 > 27'sd1048575) begin
      s1_sat = SW'(1048575);
    end else if (s1 < -27'sd1048576) begin
      s1_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      s1_sat  = s1[SW-1:0];
      clip_s1 = 1'b0;
    end
    clip_s2 = 1'b1;
    if (s2 > 28'sd1048575) begin
      s2_sat = SW'(1048575);
    end else if (s2 < -28'sd1048576) begin
      s2_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      s2_sat  = s2[SW-1:0];
      clip_s2 = 1'b0;
    end
  end

  // response select, acc holds k*v1 during write-back
  assign kv1 = acc_rnd[26:0];

  always_comb begin
    case (filter_mode)
      svf_pkg::MODE_LOWPASS:  y = {{3{v2[25]}}, v2};
      svf_pkg::MODE_BANDPASS: y = {{4{v1[24]}}, v1};
      svf_pkg::MODE_HIGHPASS: y = {{13{v0[15]}}, v0} - {{2{kv1[26]}}, kv1}
                                  - {{3{v2[25]}}, v2};
      svf_pkg::MODE_NOTCH:    y = {{13{v0[15]}}, v0} - {{2{kv1[26]}}, kv1};
      svf_pkg::MODE_PEAK:     y = {{13{v0[15]}}, v0} - {{2{kv1[26]}}, kv1}
                                  - {{2{v2[25]}}, v2, 1'b0};
      default:                y = '0;
    endcase
    clip_y = 1'b1;
    if (y > 29'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -29'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat  = y[svf_pkg::SampleW-1:0];
      clip_y = 1'b0;
    end
  end

  // integrator update on write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      first_integrator  <= '0;
      second_integrator <= '0;
    end else if (wb_fire) begin
      first_integrator  <= s1_sat;
      second_integrator <= s2_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      sample_out <= y_sat;
      clipped    <= clip_s1 | clip_s2 | clip_y;
    end
  end

  // checks on sequencing
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second sample taken while one is in work");

  a_mac_in_product: assert property (@(posedge clk) disable iff (rst)
    mac_busy |-> (state == svf_pkg::S_A1_IC1 || state == svf_pkg::S_A2_V3 ||
                  state == svf_pkg::S_A2_IC1 || state == svf_pkg::S_A3_V3 ||
                  state == svf_pkg::S_K_V1))
    else $error("multiplier running outside a product step");

  a_wb_loads_out: assert property (@(posedge clk) disable iff (rst)
    wb_fire |=> out_valid && state == svf_pkg::S_IDLE)
    else $error("write-back did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !wb_fire)
    else $error("waiting result overwritten");

endmodule
